[design/ufifo_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufifo_pkg: shared definitions of the unique value queue
// Sizes, operation and status codes, the memory request bundle, the result
// bundle and the ring index step.
// ----------------------------------------------------------------------------
package ufifo_pkg;

    localparam int DEPTH = 16;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int FUNC_W = 2;
    localparam int STATUS_W = 3;
    localparam int OCC_W = 5;

    localparam logic [FUNC_W-1:0] FUNC_ENQ = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DEQ = 2'd1;

    localparam logic [STATUS_W-1:0] ST_ENQUEUED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DEQUEUED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FOUND = 3'd5;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd6;

    typedef struct packed {
        logic              wr_en;
        logic [PTR_W-1:0]  wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [PTR_W-1:0]  rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   data;
        logic [OCC_W-1:0]    occ;
    } result_t;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] idx);
        if (idx == PTR_W'(DEPTH - 1))
        begin
            return '0;
        end
        else
        begin
            return idx + 1'b1;
        end
    endfunction

endpackage

[design/unique_value_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_value_fifo: first-in first-out queue that refuses duplicates
// Enqueue, dequeue and contains operations on a ring of signed 32-bit values,
// with a registered result port.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time. An enqueue or a contains query
// scans the queued values through the single read port of the slot memory,
// one slot per cycle, and stops early on a match. The result lands in an
// output register, and the next input transaction is taken while that
// result still waits. The slot memory needs no clearing after reset, since
// only occupied slots are read.
module unique_value_fifo (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [ufifo_pkg::FUNC_W-1:0]          func,
    input  logic signed [ufifo_pkg::DATA_W-1:0]   value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [ufifo_pkg::STATUS_W-1:0]        status,
    output logic signed [ufifo_pkg::DATA_W-1:0]   data_out,
    output logic [ufifo_pkg::OCC_W-1:0]           occupancy
);

    ufifo_pkg::mem_req_t             req;
    ufifo_pkg::result_t              res;
    logic [ufifo_pkg::DATA_W-1:0]    rd_data;
    logic                            out_free;
    logic                            out_valid_reg;
    logic [ufifo_pkg::STATUS_W-1:0]  status_reg;
    logic [ufifo_pkg::DATA_W-1:0]    data_reg;
    logic [ufifo_pkg::OCC_W-1:0]     occ_reg;

    assign out_free = !out_valid_reg || !out_stall;

    ufifo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .key      (value),
        .out_free (out_free),
        .req      (req),
        .rd_data  (rd_data),
        .res      (res)
    );

    ufifo_store u_store (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res.valid)
        begin
            status_reg <= res.status;
            data_reg <= res.data;
            occ_reg <= res.occ;
        end
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign data_out = data_reg;
    assign occupancy = occ_reg;

endmodule

[design/ufifo_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufifo_store: slot memory of the queue
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ufifo_store (
    input  logic                           clk,
    input  ufifo_pkg::mem_req_t            req,
    output logic [ufifo_pkg::DATA_W-1:0]   rd_data
);

    logic [ufifo_pkg::DATA_W-1:0] mem [ufifo_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

[design/ufifo_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufifo_ctrl: sequencer of the unique value queue
// Holds head, tail and fill count, scans the occupied slots one per cycle
// and commits the result of each operation.
// ----------------------------------------------------------------------------
module ufifo_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [ufifo_pkg::FUNC_W-1:0]   func,
    input  logic [ufifo_pkg::DATA_W-1:0]   key,
    input  logic                           out_free,
    output ufifo_pkg::mem_req_t            req,
    input  logic [ufifo_pkg::DATA_W-1:0]   rd_data,
    output ufifo_pkg::result_t             res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DEQ
    } state_t;

    state_t                        state_reg;
    logic [ufifo_pkg::PTR_W-1:0]   head_reg;
    logic [ufifo_pkg::PTR_W-1:0]   tail_reg;
    logic [ufifo_pkg::CNT_W-1:0]   fill_reg;
    logic [ufifo_pkg::PTR_W-1:0]   rd_idx_reg;
    logic [ufifo_pkg::CNT_W-1:0]   issue_cnt_reg;
    logic                          pend_reg;
    logic                          enq_reg;
    logic                          empty_reg;
    logic [ufifo_pkg::DATA_W-1:0]  key_reg;

    logic                          accept;
    logic                          hit;
    logic                          scan_end;
    logic                          full;
    logic                          do_write;
    logic [ufifo_pkg::CNT_W-1:0]   fill_next;

    always_comb
    begin
        accept = in_valid && (state_reg == S_IDLE);
        hit = pend_reg && (rd_data == key_reg);
        scan_end = hit || (issue_cnt_reg == fill_reg);
        full = (fill_reg == ufifo_pkg::CNT_W'(ufifo_pkg::DEPTH));
        do_write = (state_reg == S_SCAN) && scan_end && out_free && enq_reg
                   && !hit && !full;
        in_stall = (state_reg != S_IDLE);
    end

    always_comb
    begin
        req = '0;
        req.wr_addr = tail_reg;
        req.wr_data = key_reg;
        req.wr_en = do_write;
        if (accept && (func == ufifo_pkg::FUNC_DEQ) && (fill_reg != '0))
        begin
            req.rd_en = 1'b1;
            req.rd_addr = head_reg;
        end
        else if ((state_reg == S_SCAN) && !scan_end)
        begin
            req.rd_en = 1'b1;
            req.rd_addr = rd_idx_reg;
        end
    end

    always_comb
    begin
        res = '0;
        fill_next = fill_reg;
        unique case (state_reg)
            S_SCAN:
            begin
                res.valid = scan_end;
                if (enq_reg)
                begin
                    if (hit)
                    begin
                        res.status = ufifo_pkg::ST_DUPLICATE;
                    end
                    else if (full)
                    begin
                        res.status = ufifo_pkg::ST_FULL;
                    end
                    else
                    begin
                        res.status = ufifo_pkg::ST_ENQUEUED;
                        fill_next = fill_reg + 1'b1;
                    end
                end
                else
                begin
                    res.status = hit ? ufifo_pkg::ST_FOUND : ufifo_pkg::ST_ABSENT;
                end
            end
            S_DEQ:
            begin
                res.valid = 1'b1;
                if (empty_reg)
                begin
                    res.status = ufifo_pkg::ST_EMPTY;
                    res.data = '1;
                end
                else
                begin
                    res.status = ufifo_pkg::ST_DEQUEUED;
                    res.data = rd_data;
                    fill_next = fill_reg - 1'b1;
                end
            end
            default:
            begin
                res.valid = 1'b0;
            end
        endcase
        res.occ = ufifo_pkg::OCC_W'(fill_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
            rd_idx_reg <= '0;
            issue_cnt_reg <= '0;
            pend_reg <= 1'b0;
            enq_reg <= 1'b0;
            empty_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        enq_reg <= (func == ufifo_pkg::FUNC_ENQ);
                        empty_reg <= (fill_reg == '0);
                        rd_idx_reg <= head_reg;
                        issue_cnt_reg <= '0;
                        pend_reg <= 1'b0;
                        state_reg <= (func == ufifo_pkg::FUNC_DEQ) ? S_DEQ : S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (!scan_end)
                    begin
                        pend_reg <= 1'b1;
                        rd_idx_reg <= ufifo_pkg::ring_next(rd_idx_reg);
                        issue_cnt_reg <= issue_cnt_reg + 1'b1;
                    end
                    else if (out_free)
                    begin
                        fill_reg <= fill_next;
                        if (do_write)
                        begin
                            tail_reg <= ufifo_pkg::ring_next(tail_reg);
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_DEQ:
                begin
                    if (out_free)
                    begin
                        fill_reg <= fill_next;
                        if (!empty_reg)
                        begin
                            head_reg <= ufifo_pkg::ring_next(head_reg);
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= key;
        end
    end

endmodule
